// ===== src/sfp_pkg.sv =====
// Shared types and constants for the sync-framed message parser.
// Used by sfp_cfg, sfp_core, sfp_out and sync_frame_parser_fletcher8.
`default_nettype none
package sfp_pkg;

  localparam int MAX_PAYLOAD = 1024;
  localparam int IDX_W = 10;
  localparam int POS_W = ($clog2(MAX_PAYLOAD + 1) > IDX_W) ? $clog2(MAX_PAYLOAD + 1) : IDX_W;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h62;

  localparam logic [7:0] ACK_CLASS = 8'h05;
  localparam logic [7:0] ACK_ID    = 8'h01;
  localparam logic [7:0] NACK_ID   = 8'h00;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // Configuration register indexes (byte address bit 2).
  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_BAD_CK   = 2'd2,
    KIND_TOO_LONG = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        data;
    logic [IDX_W-1:0]  byte_index;
    logic [7:0]        frame_class;
    logic [7:0]        msg_id;
    logic [15:0]       frame_length;
    logic [15:0]       good_count;
    logic [15:0]       error_count;
    logic              ack_seen;
    logic              nack_seen;
  } result_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
  } cfg_t;

endpackage
`default_nettype wire

// ===== src/sfp_cfg.sv =====
// APB-style configuration registers holding the two sync byte values.
// Depends on sfp_pkg for reset values and register indexes.
`default_nettype none
module sfp_cfg
  import sfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output cfg_t             cfg
);

  logic [7:0] sync_first_r;
  logic [7:0] sync_second_r;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
    end else if (wr_en) begin
      if (cfg_paddr[2] == REG_SYNC_FIRST) sync_first_r <= cfg_pwdata[7:0];
      else                                sync_second_r <= cfg_pwdata[7:0];
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_SYNC_FIRST) cfg_prdata = {24'd0, sync_first_r};
    else                                cfg_prdata = {24'd0, sync_second_r};
  end

  assign cfg.sync_first  = sync_first_r;
  assign cfg.sync_second = sync_second_r;

endmodule
`default_nettype wire

// ===== src/sfp_core.sv =====
// Frame state machine, running Fletcher-8 sum, counters and sticky flags.
// Computes at most one result per accepted byte; depends on sfp_pkg.
`default_nettype none
module sfp_core
  import sfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  input  wire cfg_t       cfg,
  output logic            res_valid,
  output result_t         res
);

  typedef enum logic [2:0] {
    PH_WAIT, PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI, PH_DATA, PH_CK_A, PH_CK_B
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       last_byte_r;
  logic [7:0]       class_r, class_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       sum_a_r, sum_a_nxt;
  logic [7:0]       sum_b_r, sum_b_nxt;
  logic [7:0]       ck_a_r, ck_a_nxt;
  logic [15:0]      good_r, good_nxt;
  logic [15:0]      bad_r, bad_nxt;
  logic             ack_r, ack_nxt;
  logic             nack_r, nack_nxt;
  logic [7:0]       add_a, add_b;
  logic [15:0]      len_full;
  logic [POS_W:0]   pos_inc;
  kind_t            kind;

  assign add_a    = sum_a_r + rx_byte;
  assign add_b    = sum_b_r + add_a;
  assign len_full = {rx_byte, len_r[7:0]};
  assign pos_inc  = {1'b0, pos_r} + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    class_nxt = class_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    ck_a_nxt  = ck_a_r;
    good_nxt  = good_r;
    bad_nxt   = bad_r;
    ack_nxt   = ack_r;
    nack_nxt  = nack_r;
    res_valid = 1'b0;
    kind      = KIND_PAYLOAD;
    unique case (phase_r)
      PH_WAIT: begin
        if (rx_byte == cfg.sync_second && last_byte_r == cfg.sync_first) begin
          phase_nxt = PH_CLASS;
          class_nxt = '0;
          id_nxt    = '0;
          len_nxt   = '0;
          pos_nxt   = '0;
          sum_a_nxt = '0;
          sum_b_nxt = '0;
          ck_a_nxt  = '0;
        end
      end
      PH_CLASS: begin
        class_nxt = rx_byte;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_ID;
      end
      PH_ID: begin
        id_nxt    = rx_byte;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_nxt   = {8'd0, rx_byte};
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_nxt   = len_full;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        pos_nxt   = '0;
        if (len_full > 16'(MAX_PAYLOAD)) begin
          bad_nxt   = (bad_r == CNT_MAX) ? bad_r : bad_r + 16'd1;
          phase_nxt = PH_WAIT;
          kind      = KIND_TOO_LONG;
          res_valid = 1'b1;
        end else if (len_full == 16'd0) begin
          phase_nxt = PH_CK_A;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        kind      = KIND_PAYLOAD;
        res_valid = 1'b1;
        if (17'(pos_inc) >= {1'b0, len_r}) phase_nxt = PH_CK_A;
        pos_nxt = pos_inc[POS_W-1:0];
      end
      PH_CK_A: begin
        ck_a_nxt  = rx_byte;
        phase_nxt = PH_CK_B;
      end
      PH_CK_B: begin
        phase_nxt = PH_WAIT;
        res_valid = 1'b1;
        if (ck_a_r == sum_a_r && rx_byte == sum_b_r) begin
          good_nxt = (good_r == CNT_MAX) ? good_r : good_r + 16'd1;
          if (class_r == ACK_CLASS) begin
            if (id_r == ACK_ID)       ack_nxt  = 1'b1;
            else if (id_r == NACK_ID) nack_nxt = 1'b1;
          end
          kind = KIND_GOOD;
        end else begin
          bad_nxt = (bad_r == CNT_MAX) ? bad_r : bad_r + 16'd1;
          kind    = KIND_BAD_CK;
        end
      end
      default: phase_nxt = PH_WAIT;
    endcase
  end

  // Result fields carry the state as it stands after this byte.
  always_comb begin
    res.kind         = kind;
    res.data         = (kind == KIND_PAYLOAD) ? rx_byte : 8'd0;
    res.byte_index   = (kind == KIND_PAYLOAD) ? pos_r[IDX_W-1:0] : '0;
    res.frame_class  = class_nxt;
    res.msg_id       = id_nxt;
    res.frame_length = len_nxt;
    res.good_count   = good_nxt;
    res.error_count  = bad_nxt;
    res.ack_seen     = ack_nxt;
    res.nack_seen    = nack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      last_byte_r <= '0;
      class_r     <= '0;
      id_r        <= '0;
      len_r       <= '0;
      pos_r       <= '0;
      sum_a_r     <= '0;
      sum_b_r     <= '0;
      ck_a_r      <= '0;
      good_r      <= '0;
      bad_r       <= '0;
      ack_r       <= 1'b0;
      nack_r      <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      last_byte_r <= rx_byte;
      class_r     <= class_nxt;
      id_r        <= id_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      sum_a_r     <= sum_a_nxt;
      sum_b_r     <= sum_b_nxt;
      ck_a_r      <= ck_a_nxt;
      good_r      <= good_nxt;
      bad_r       <= bad_nxt;
      ack_r       <= ack_nxt;
      nack_r      <= nack_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/sfp_out.sv =====
// Output register for result beats; accepts a new result in the cycle
// the held one is taken. Depends on sfp_pkg for the result struct.
`default_nettype none
module sfp_out
  import sfp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t res,
  output logic         can_load,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_res
);

  logic    valid_r;
  result_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res;
  end

endmodule
`default_nettype wire

// ===== src/sync_frame_parser_fletcher8.sv =====
// Top level of the sync-framed message parser with Fletcher-8 check.
// Instantiates sfp_cfg, sfp_core and sfp_out; depends on sfp_pkg.
//
// Use: received bytes enter one per beat on the in_ stream (in_tdata holds
// the byte). The parser hunts for the two sync bytes, reads class, id and a
// little-endian 16-bit length, forwards each payload byte as a beat on the
// out_ stream, and ends each frame with one beat saying good, checksum
// failure or length too long. Sync bytes, the other header bytes and the
// first check byte give no beat. out_tuser carries the beat kind; out_tdata
// carries the byte, its index and the frame and counter status.
// A result is registered and appears on out_ in the cycle after its byte is accepted.
// Throughput: one byte per cycle while in_tready is high; the state update and
// running sum finish in the cycle the byte is accepted.
// Stall: while a result waits and out_tready is low, in_tready is low;
// in_tready follows out_tready in the same cycle, so nothing is dropped.
// Reset (rst_n low, synchronous) clears the parser, counters and flags and
// loads the sync registers with 0xB5 and 0x62. Registers sit on the cfg_
// APB port at byte addresses 0 (first sync) and 4 (second sync).
`default_nettype none
module sync_frame_parser_fletcher8
  import sfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // [7:0] data, [17:8] byte_index,
                                       // [25:18] frame_class, [33:26] msg_id,
                                       // [49:34] frame_length,
                                       // [65:50] good_count,
                                       // [81:66] error_count, [82] ack_seen,
                                       // [83] nack_seen, [87:84] zero
  output logic [1:0]       out_tuser,  // [1:0] kind
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  cfg_t    cfg;
  logic    step;
  logic    res_valid;
  result_t res;
  logic    can_load;
  result_t out_res;

  assign in_tready = can_load;
  assign step      = in_tvalid && in_tready;

  sfp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  sfp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (in_tdata),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  sfp_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tuser = out_res.kind;
  assign out_tdata = {4'd0, out_res.nack_seen, out_res.ack_seen, out_res.error_count,
                      out_res.good_count, out_res.frame_length, out_res.msg_id,
                      out_res.frame_class, out_res.byte_index, out_res.data};

endmodule
`default_nettype wire

// ===== dv/sync_frame_parser_fletcher8_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sync_frame_parser_fletcher8: drives byte streams
// and sync register writes, and predicts every result beat with its own parser.
// Depends on sfp_pkg and the RTL of the parser; needs no other files.
module sync_frame_parser_fletcher8_test
  import sfp_pkg::*;
();

  localparam int QUIET_LIMIT = 4000;

  typedef enum logic [2:0] {
    ST_HUNT, ST_CLASS, ST_ID, ST_LEN_LO, ST_LEN_HI, ST_PAYLOAD, ST_CK_A, ST_CK_B
  } parse_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Parser state as the testbench expects it.
  logic [7:0]   sync1 = SYNC_FIRST_RST;
  logic [7:0]   sync2 = SYNC_SECOND_RST;
  parse_state_t ph = ST_HUNT;
  logic [7:0]   prev_byte = 8'h00;
  logic [7:0]   frm_class = 8'h00;
  logic [7:0]   frm_id = 8'h00;
  logic [15:0]  frm_len = 16'h0000;
  logic [15:0]  pay_pos = 16'h0000;
  logic [15:0]  run_sum = 16'h0000;  // {sum_b, sum_a}
  logic [7:0]   check_a = 8'h00;
  logic [15:0]  good_cnt = 16'h0000;
  logic [15:0]  bad_cnt = 16'h0000;
  logic         ack_flag = 1'b0;
  logic         nack_flag = 1'b0;

  result_t parser_results_due[$];
  int      mismatches = 0;
  int      bytes_sent = 0;
  int      quiet_cycles = 0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;

  sync_frame_parser_fletcher8 dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [15:0] fletcher_step(logic [15:0] sums, logic [7:0] b);
    logic [7:0] a;
    logic [7:0] s;
    a = sums[7:0] + b;
    s = sums[15:8] + a;
    return {s, a};
  endfunction

  function automatic string describe_result(result_t r);
    return $sformatf("k=%0d d=%h i=%0d cls=%h id=%h len=%0d good=%0d err=%0d ack=%b nack=%b",
                     r.kind, r.data, r.byte_index, r.frame_class, r.msg_id, r.frame_length,
                     r.good_count, r.error_count, r.ack_seen, r.nack_seen);
  endfunction

  // Advances the expected parser by one received byte.
  task automatic parse_byte(input logic [7:0] b, output bit emit, output result_t r);
    emit = 1'b0;
    r = '0;
    case (ph)
      ST_HUNT: begin
        if (b == sync2 && prev_byte == sync1) begin
          ph = ST_CLASS;
          frm_class = 8'h00;
          frm_id = 8'h00;
          frm_len = 16'h0000;
          pay_pos = 16'h0000;
          run_sum = 16'h0000;
          check_a = 8'h00;
        end
      end
      ST_CLASS: begin
        frm_class = b;
        run_sum = fletcher_step(run_sum, b);
        ph = ST_ID;
      end
      ST_ID: begin
        frm_id = b;
        run_sum = fletcher_step(run_sum, b);
        ph = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        frm_len = {8'h00, b};
        run_sum = fletcher_step(run_sum, b);
        ph = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        frm_len[15:8] = b;
        run_sum = fletcher_step(run_sum, b);
        pay_pos = 16'h0000;
        if (frm_len > MAX_PAYLOAD) begin
          if (bad_cnt != CNT_MAX) bad_cnt = bad_cnt + 16'd1;
          ph = ST_HUNT;
          emit = 1'b1;
          r.kind = KIND_TOO_LONG;
        end else if (frm_len == 16'h0000) begin
          ph = ST_CK_A;
        end else begin
          ph = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        run_sum = fletcher_step(run_sum, b);
        emit = 1'b1;
        r.kind = KIND_PAYLOAD;
        r.data = b;
        r.byte_index = pay_pos[IDX_W-1:0];
        if (pay_pos + 1 >= frm_len) ph = ST_CK_A;
        pay_pos = pay_pos + 16'd1;
      end
      ST_CK_A: begin
        check_a = b;
        ph = ST_CK_B;
      end
      default: begin
        ph = ST_HUNT;
        emit = 1'b1;
        if (check_a == run_sum[7:0] && b == run_sum[15:8]) begin
          if (good_cnt != CNT_MAX) good_cnt = good_cnt + 16'd1;
          if (frm_class == ACK_CLASS) begin
            if (frm_id == ACK_ID) ack_flag = 1'b1;
            else if (frm_id == NACK_ID) nack_flag = 1'b1;
          end
          r.kind = KIND_GOOD;
        end else begin
          if (bad_cnt != CNT_MAX) bad_cnt = bad_cnt + 16'd1;
          r.kind = KIND_BAD_CK;
        end
      end
    endcase
    prev_byte = b;
    if (emit) begin
      r.frame_class = frm_class;
      r.msg_id = frm_id;
      r.frame_length = frm_len;
      r.good_count = good_cnt;
      r.error_count = bad_cnt;
      r.ack_seen = ack_flag;
      r.nack_seen = nack_flag;
    end
  endtask

  // Output beats are checked before the input beat of the same edge is predicted,
  // so a result can never be matched against the byte that arrives with it.
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    result_t predicted;
    bit      produced;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen.kind = kind_t'(out_tuser);
        seen.data = out_tdata[7:0];
        seen.byte_index = out_tdata[17:8];
        seen.frame_class = out_tdata[25:18];
        seen.msg_id = out_tdata[33:26];
        seen.frame_length = out_tdata[49:34];
        seen.good_count = out_tdata[65:50];
        seen.error_count = out_tdata[81:66];
        seen.ack_seen = out_tdata[82];
        seen.nack_seen = out_tdata[83];
        if (parser_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: %s", describe_result(seen));
        end else begin
          want = parser_results_due.pop_front();
          if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected %s", describe_result(want));
              $display("                 actual   %s", describe_result(seen));
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        parse_byte(in_tdata, produced, predicted);
        if (produced) parser_results_due.push_back(predicted);
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Stops sending and waits for every outstanding result plus the block latency.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (parser_results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_sync_reg(input logic idx, input logic [7:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {24'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if (idx == REG_SYNC_FIRST) sync1 = value;
    else sync2 = value;
  endtask

  task automatic set_sync(input logic [7:0] first, input logic [7:0] second);
    drain_results();
    write_sync_reg(REG_SYNC_FIRST, first);
    write_sync_reg(REG_SYNC_SECOND, second);
  endtask

  // Sends a whole frame; an over-long frame stops after its header.
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id, input int len,
                            input bit corrupt);
    logic [7:0]  body[$];
    logic [15:0] len_v;
    logic [15:0] ck;
    len_v = len[15:0];
    ck = 16'h0000;
    body.push_back(cls);
    body.push_back(id);
    body.push_back(len_v[7:0]);
    body.push_back(len_v[15:8]);
    if (len <= MAX_PAYLOAD) begin
      for (int i = 0; i < len; i++) body.push_back(8'($urandom_range(255)));
    end
    foreach (body[i]) ck = fletcher_step(ck, body[i]);
    if (corrupt) ck = ck ^ (16'd1 << $urandom_range(15));
    send_byte(sync1);
    send_byte(sync2);
    foreach (body[i]) send_byte(body[i]);
    if (len <= MAX_PAYLOAD) begin
      send_byte(ck[7:0]);
      send_byte(ck[15:8]);
    end
  endtask

  task automatic test_directed_frames();
    send_idle_pct = 34;
    stall_pct = 34;
    send_frame(ACK_CLASS, ACK_ID, 0, 1'b0);
    send_frame(ACK_CLASS, NACK_ID, 1, 1'b0);
    send_frame(8'hFF, 8'hFF, MAX_PAYLOAD + 1, 1'b0);
  endtask

  task automatic test_length_limits();
    send_idle_pct = 0;
    stall_pct = 0;
    send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), MAX_PAYLOAD, 1'b0);
    send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 65535, 1'b0);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall,
                                     input logic [7:0] first, input logic [7:0] second,
                                     input int n_bytes);
    int start;
    int pick;
    int len;
    logic [7:0] cls;
    logic [7:0] id;
    set_sync(first, second);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 62) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(9, 48) : $urandom_range(0, 8);
        cls = ($urandom_range(3) == 0) ? ACK_CLASS : 8'($urandom_range(255));
        case ($urandom_range(2))
          0: id = ACK_ID;
          1: id = NACK_ID;
          default: id = 8'($urandom_range(255));
        endcase
        send_frame(cls, id, len, $urandom_range(4) == 0);
      end else if (pick < 72) begin
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)),
                   $urandom_range(MAX_PAYLOAD + 1, 65535), 1'b0);
      end else if (pick < 80) begin
        // A frame cut short: whatever follows is taken as its remaining bytes.
        send_byte(sync1);
        send_byte(sync2);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 4))
          send_byte(($urandom_range(3) == 0) ? sync1 : 8'($urandom_range(255)));
      end
      // Now and then hold off until the parser has delivered everything.
      if ($urandom_range(19) == 0) drain_results();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_length_limits();
    test_random_traffic(0, 0, SYNC_FIRST_RST, SYNC_SECOND_RST, 50);
    test_random_traffic(64, 0, 8'h00, 8'hFF, 50);
    test_random_traffic(0, 64, 8'hFF, 8'h00, 50);
    test_random_traffic(34, 34, 8'($urandom_range(255)), 8'($urandom_range(255)), 50);
    test_random_traffic(34, 34, 8'hAA, 8'hAA, 50);
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && parser_results_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/sfp_pkg.sv
src/sfp_cfg.sv
src/sfp_core.sv
src/sfp_out.sv
src/sync_frame_parser_fletcher8.sv
dv/sync_frame_parser_fletcher8_test.sv
